[rtl/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_WANT_BS,
    PH_WANT_U,
    PH_LOW_HEX
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NO_QUOTE,
    ERR_CONTROL,
    ERR_ESCAPE
  } err_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_U         = 8'h75;

  // One queue entry: the data bytes of one input transfer plus an optional
  // closing result.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_term;
    kind_t           term_kind;
    err_t            term_code;
  } job_t;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[rtl/json_string_unescape_utf8_core.sv]
// Top level of the JSON string unescaper to UTF-8.
// Takes one byte of a quoted JSON string per transfer and gives the decoded
// UTF-8 bytes, then a completion or error result, one result per transfer.
// Input is taken every cycle while the entry queue has room; a byte enters
// the queue as one entry holding all results it causes (up to four data bytes
// and one closing result), so the output side delivers one result per cycle
// while out_ready is high; a \u surrogate pair gives up to four bytes. Entries
// are registered in the queue before their results are presented. Bytes of a
// failing string are delivered before its error result.
module json_string_unescape_utf8_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_of_string,
  input  logic [7:0] data_byte,
  input  logic       last_available,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] result_kind,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  jsu_pkg::job_t push_job, head_job;
  logic          push, full, pop, not_empty;

  jsu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .start_of_string (start_of_string),
    .data_byte       (data_byte),
    .last_available  (last_available),
    .q_full          (full),
    .q_push          (push),
    .q_job           (push_job)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (not_empty),
    .q_head      (head_job),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .result_kind (result_kind),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

[rtl/jsu_front.sv]
// Front end: decode state machine, turns each input byte that yields a result into one queue entry.
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             start_of_string,
  input  logic [7:0]       data_byte,
  input  logic             last_available,
  input  logic             q_full,
  output logic             q_push,
  output jsu_pkg::job_t    q_job
);

  jsu_pkg::phase_t phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] acc, acc_next;
  logic [9:0]  high_bits, high_bits_next;

  logic        fire;
  logic [4:0]  hex;
  logic [15:0] acc_new;
  logic        is_high, is_low;
  logic [20:0] cp;

  logic        active, fail, quote_close, ctrl_err, start_err, esc_err;
  logic        emit1, emit_cp;
  logic [7:0]  emit_b;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign hex      = jsu_pkg::hex_value(data_byte);
  assign acc_new  = {acc[11:0], hex[3:0]};
  assign is_high  = (acc_new[15:10] == 6'b110110);
  assign is_low   = (acc_new[15:10] == 6'b110111);
  assign cp = (phase == jsu_pkg::PH_LOW_HEX) ?
              (21'h010000 + {1'b0, high_bits, acc_new[9:0]}) : {5'd0, acc_new};

  // next state
  always_comb begin
    phase_next     = phase;
    hex_count_next = hex_count;
    acc_next       = acc;
    high_bits_next = high_bits;
    active      = 1'b1;
    fail        = 1'b0;
    quote_close = 1'b0;
    ctrl_err    = 1'b0;
    start_err   = 1'b0;
    emit1       = 1'b0;
    emit_cp     = 1'b0;
    emit_b      = data_byte;
    if (start_of_string) begin
      hex_count_next = 2'd0;
      acc_next       = 16'd0;
      high_bits_next = 10'd0;
      if (data_byte != jsu_pkg::CH_QUOTE) begin
        start_err  = 1'b1;
        phase_next = jsu_pkg::PH_IDLE;
      end else begin
        phase_next = jsu_pkg::PH_BODY;
      end
    end else begin
      unique case (phase) inside
        jsu_pkg::PH_BODY: begin
          if (data_byte == jsu_pkg::CH_QUOTE) quote_close = 1'b1;
          else if (data_byte < jsu_pkg::CH_SPACE) ctrl_err = 1'b1;
          else if (data_byte == jsu_pkg::CH_BACKSLASH) phase_next = jsu_pkg::PH_ESC;
          else emit1 = 1'b1;
        end
        jsu_pkg::PH_ESC: begin
          phase_next = jsu_pkg::PH_BODY;
          emit1 = 1'b1;
          case (data_byte) inside
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: emit_b = data_byte;
            8'h62:   emit_b = 8'h08;
            8'h66:   emit_b = 8'h0c;
            8'h6e:   emit_b = 8'h0a;
            8'h72:   emit_b = 8'h0d;
            8'h74:   emit_b = 8'h09;
            jsu_pkg::CH_U: begin
              emit1          = 1'b0;
              phase_next     = jsu_pkg::PH_HEX;
              hex_count_next = 2'd0;
              acc_next       = 16'd0;
            end
            default: begin
              emit1 = 1'b0;
              fail  = 1'b1;
            end
          endcase
        end
        jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
          if (!hex[4]) begin
            fail = 1'b1;
          end else begin
            acc_next = acc_new;
            if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
            end else begin
              hex_count_next = 2'd0;
              if (phase == jsu_pkg::PH_HEX) begin
                if (is_high) begin
                  high_bits_next = acc_new[9:0];
                  phase_next     = jsu_pkg::PH_WANT_BS;
                end else if (is_low || acc_new == 16'd0) begin
                  fail = 1'b1;
                end else begin
                  emit_cp    = 1'b1;
                  phase_next = jsu_pkg::PH_BODY;
                end
              end else begin
                if (!is_low) begin
                  fail = 1'b1;
                end else begin
                  emit_cp    = 1'b1;
                  phase_next = jsu_pkg::PH_BODY;
                end
              end
            end
          end
        end
        jsu_pkg::PH_WANT_BS: begin
          if (data_byte == jsu_pkg::CH_BACKSLASH) phase_next = jsu_pkg::PH_WANT_U;
          else fail = 1'b1;
        end
        jsu_pkg::PH_WANT_U: begin
          if (data_byte == jsu_pkg::CH_U) begin
            phase_next     = jsu_pkg::PH_LOW_HEX;
            hex_count_next = 2'd0;
            acc_next       = 16'd0;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          active     = 1'b0;
          phase_next = jsu_pkg::PH_IDLE;
        end
      endcase
    end
    esc_err = active && !start_err &&
              (fail || (last_available && !quote_close && !ctrl_err));
    if (esc_err || quote_close || ctrl_err) begin
      phase_next     = jsu_pkg::PH_IDLE;
      hex_count_next = 2'd0;
      acc_next       = 16'd0;
      high_bits_next = 10'd0;
    end
  end

  // queue entry
  always_comb begin
    q_job           = '0;
    q_job.term_kind = jsu_pkg::KIND_DATA;
    q_job.term_code = jsu_pkg::ERR_NONE;
    if (emit1) begin
      q_job.nbytes   = 3'd1;
      q_job.bytes[0] = emit_b;
    end else if (emit_cp) begin
      if (cp <= 21'h7f) begin
        q_job.nbytes   = 3'd1;
        q_job.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7ff) begin
        q_job.nbytes   = 3'd2;
        q_job.bytes[0] = {3'b110, cp[10:6]};
        q_job.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
        q_job.nbytes   = 3'd3;
        q_job.bytes[0] = {4'b1110, cp[15:12]};
        q_job.bytes[1] = {2'b10, cp[11:6]};
        q_job.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        q_job.nbytes   = 3'd4;
        q_job.bytes[0] = {5'b11110, cp[20:18]};
        q_job.bytes[1] = {2'b10, cp[17:12]};
        q_job.bytes[2] = {2'b10, cp[11:6]};
        q_job.bytes[3] = {2'b10, cp[5:0]};
      end
    end
    if (start_err) begin
      q_job.has_term  = 1'b1;
      q_job.term_kind = jsu_pkg::KIND_ERROR;
      q_job.term_code = jsu_pkg::ERR_NO_QUOTE;
    end else if (quote_close) begin
      q_job.has_term  = 1'b1;
      q_job.term_kind = jsu_pkg::KIND_DONE;
    end else if (ctrl_err) begin
      q_job.has_term  = 1'b1;
      q_job.term_kind = jsu_pkg::KIND_ERROR;
      q_job.term_code = jsu_pkg::ERR_CONTROL;
    end else if (esc_err) begin
      q_job.has_term  = 1'b1;
      q_job.term_kind = jsu_pkg::KIND_ERROR;
      q_job.term_code = jsu_pkg::ERR_ESCAPE;
    end
  end

  assign q_push = fire && (q_job.nbytes != 3'd0 || q_job.has_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jsu_pkg::PH_IDLE;
      hex_count <= 2'd0;
      acc       <= 16'd0;
      high_bits <= 10'd0;
    end else if (fire) begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
      acc       <= acc_next;
      high_bits <= high_bits_next;
    end
  end

endmodule

[rtl/jsu_queue.sv]
// Small register queue of decoded entries between front and back end.
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output jsu_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_job  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

[rtl/jsu_back.sv]
// Back end: walks the head entry and presents one result per transfer.
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  jsu_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    result_kind,
  output logic [1:0]    error_code,
  output logic          last_of_run
);

  logic [2:0] idx;
  logic [2:0] total;
  logic       is_byte;

  assign total       = q_head.nbytes + {2'b00, q_head.has_term};
  assign is_byte     = (idx < q_head.nbytes);
  assign out_valid   = q_not_empty;
  assign out_byte    = is_byte ? q_head.bytes[idx[1:0]] : 8'd0;
  assign result_kind = is_byte ? jsu_pkg::KIND_DATA : q_head.term_kind;
  assign error_code  = is_byte ? jsu_pkg::ERR_NONE : q_head.term_code;
  assign last_of_run = (idx == total - 3'd1);
  assign q_pop       = out_valid && out_ready && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (out_valid && out_ready) begin
      idx <= last_of_run ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

[rtl/jsu_checker.sv]
// Port-level assertions for the unescaper, bound to the top level.
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] result_kind,
  input logic [1:0] error_code,
  input logic       last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(result_kind) && $stable(error_code) && $stable(last_of_run))
    else $error("output changed while stalled");

  a_run_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("run broken by a gap");

  a_term_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != jsu_pkg::KIND_DATA |-> last_of_run)
    else $error("closing result not last of run");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with nothing queued");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescape_utf8_core: random JSON strings in, UTF-8 out.
module tb;

  localparam int RUN_ITEMS      = 420;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 120;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 20;

  localparam logic [7:0] SIMPLE_ESC [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH,
                                            jsu_pkg::CH_SLASH,
                                            "b", "f", "n", "r", "t"};

  typedef struct {
    logic       sos;
    logic [7:0] ch;
    logic       fin;
    int         gap;
    logic       drain;
  } json_byte_t;

  typedef struct packed {
    logic [7:0]     ob;
    jsu_pkg::kind_t kind;
    jsu_pkg::err_t  code;
    logic           last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       start_of_string = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_available = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [1:0] error_code;
  logic       last_of_run;

  json_byte_t text_bytes[$];
  decoded_t   utf8_expected[$];
  decoded_t   want;

  // decoder mirror
  jsu_pkg::phase_t dec_phase = jsu_pkg::PH_IDLE;
  logic [1:0]  hex_count = '0;
  logic [15:0] unit_acc = '0;
  logic [9:0]  high_bits = '0;

  int   fail_count = 0;
  int   results_seen = 0;
  int   idle_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   first_random;
  logic held_once = 1'b0;
  logic steady = 1'b0;
  logic calm = 1'b0;

  json_string_unescape_utf8_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .start_of_string (start_of_string),
    .data_byte       (data_byte),
    .last_available  (last_available),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .result_kind     (result_kind),
    .error_code      (error_code),
    .last_of_run     (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_result(logic [7:0] b, jsu_pkg::kind_t k, jsu_pkg::err_t e);
    decoded_t r;
    r.ob   = b;
    r.kind = k;
    r.code = e;
    r.last = 1'b0;
    utf8_expected.push_back(r);
  endfunction

  function automatic void unescape_byte(logic sos, logic [7:0] c, logic fin);
    int          base;
    logic        open;
    logic        fail;
    logic        emit;
    logic        ignored;
    logic        hex_ok;
    logic [3:0]  nib;
    logic [20:0] cp;
    base    = utf8_expected.size();
    open    = 1'b1;
    fail    = 1'b0;
    emit    = 1'b0;
    ignored = 1'b0;
    hex_ok  = 1'b0;
    nib     = '0;
    cp      = '0;
    if (sos) begin
      hex_count = '0;
      unit_acc  = '0;
      high_bits = '0;
      if (c != jsu_pkg::CH_QUOTE) begin
        add_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE);
        open = 1'b0;
      end else begin
        dec_phase = jsu_pkg::PH_BODY;
      end
    end else begin
      case (dec_phase) inside
        jsu_pkg::PH_BODY: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            add_result(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
            open = 1'b0;
          end else if (c < jsu_pkg::CH_SPACE) begin
            add_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CONTROL);
            open = 1'b0;
          end else if (c == jsu_pkg::CH_BACKSLASH) begin
            dec_phase = jsu_pkg::PH_ESC;
          end else begin
            add_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
          end
        end
        jsu_pkg::PH_ESC: begin
          dec_phase = jsu_pkg::PH_BODY;
          case (c) inside
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
              add_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            "b": add_result(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            "f": add_result(8'h0c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            "n": add_result(8'h0a, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            "r": add_result(8'h0d, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            "t": add_result(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_U: begin
              dec_phase = jsu_pkg::PH_HEX;
              hex_count = '0;
              unit_acc  = '0;
            end
            default: fail = 1'b1;
          endcase
        end
        jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
          if (c >= "0" && c <= "9") begin
            hex_ok = 1'b1;
            nib    = c[3:0];
          end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            hex_ok = 1'b1;
            nib    = 4'(c - ((c >= "a") ? 8'h57 : 8'h37));
          end
          if (!hex_ok) begin
            fail = 1'b1;
          end else begin
            unit_acc = {unit_acc[11:0], nib};
            if (hex_count != 2'd3) begin
              hex_count = hex_count + 2'd1;
            end else begin
              hex_count = '0;
              if (dec_phase == jsu_pkg::PH_HEX) begin
                if (unit_acc >= 16'hd800 && unit_acc <= 16'hdbff) begin
                  high_bits = 10'(unit_acc - 16'hd800);
                  dec_phase = jsu_pkg::PH_WANT_BS;
                end else if ((unit_acc >= 16'hdc00 && unit_acc <= 16'hdfff) ||
                             unit_acc == 16'h0000) begin
                  fail = 1'b1;
                end else begin
                  emit      = 1'b1;
                  cp        = 21'(unit_acc);
                  dec_phase = jsu_pkg::PH_BODY;
                end
              end else if (unit_acc < 16'hdc00 || unit_acc > 16'hdfff) begin
                fail = 1'b1;
              end else begin
                emit      = 1'b1;
                cp        = 21'h10000 + {1'b0, high_bits, 10'(unit_acc - 16'hdc00)};
                dec_phase = jsu_pkg::PH_BODY;
              end
            end
          end
        end
        jsu_pkg::PH_WANT_BS: begin
          if (c == jsu_pkg::CH_BACKSLASH) dec_phase = jsu_pkg::PH_WANT_U;
          else fail = 1'b1;
        end
        jsu_pkg::PH_WANT_U: begin
          if (c == jsu_pkg::CH_U) begin
            dec_phase = jsu_pkg::PH_LOW_HEX;
            hex_count = '0;
            unit_acc  = '0;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          dec_phase = jsu_pkg::PH_IDLE;
          ignored   = 1'b1;
        end
      endcase
    end

    if (emit) begin
      if (cp <= 21'h7f) begin
        add_result(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (cp <= 21'h7ff) begin
        add_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (cp <= 21'hffff) begin
        add_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else begin
        add_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        add_result({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end
    end

    if (!ignored) begin
      if (fail || (open && fin)) begin
        add_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_ESCAPE);
        open = 1'b0;
      end
      if (!open) begin
        dec_phase = jsu_pkg::PH_IDLE;
        hex_count = '0;
        unit_acc  = '0;
        high_bits = '0;
      end
    end
    if (utf8_expected.size() > base) utf8_expected[utf8_expected.size() - 1].last = 1'b1;
  endfunction

  // stimulus builders

  function automatic void put_byte(logic sos, logic [7:0] c, logic fin);
    json_byte_t t;
    t.sos   = sos;
    t.ch    = c;
    t.fin   = fin;
    t.gap   = steady ? 0 : pick_gap();
    t.drain = 1'b0;
    text_bytes.push_back(t);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + {4'h0, nib};
  endfunction

  function automatic void put_u(logic [15:0] v);
    put_byte(1'b0, jsu_pkg::CH_BACKSLASH, 1'b0);
    put_byte(1'b0, jsu_pkg::CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) put_byte(1'b0, hex_char(v[4*i +: 4]), 1'b0);
  endfunction

  function automatic logic [15:0] bmp_unit();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0001, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  function automatic logic [15:0] high_unit();
    return 16'(16'hd800 + $urandom_range(0, 16'h3ff));
  endfunction

  function automatic void put_piece();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        do c = 8'($urandom_range(32, 255));
        while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
        put_byte(1'b0, c, 1'b0);
      end
      3: begin
        put_byte(1'b0, jsu_pkg::CH_BACKSLASH, 1'b0);
        put_byte(1'b0, SIMPLE_ESC[$urandom_range(0, 7)], 1'b0);
      end
      4, 5: put_u(bmp_unit());
      default: begin
        put_u(high_unit());
        put_u(16'(16'hdc00 + $urandom_range(0, 16'h3ff)));
      end
    endcase
  endfunction

  function automatic void put_string();
    int         pieces;
    logic [7:0] c;
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 19) == 0) begin
      do c = 8'($urandom()); while (c == jsu_pkg::CH_QUOTE);
      put_byte(1'b1, c, 1'($urandom_range(0, 1)));
    end else begin
      put_byte(1'b1, jsu_pkg::CH_QUOTE, 1'b0);
      pieces = $urandom_range(0, 6);
      for (int i = 0; i < pieces; i++) put_piece();
      case ($urandom_range(0, 16))
        9: put_byte(1'b0, 8'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        10: begin
          do c = 8'($urandom());
          while (c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH,
                           "b", "f", "n", "r", "t", jsu_pkg::CH_U});
          put_byte(1'b0, jsu_pkg::CH_BACKSLASH, 1'b0);
          put_byte(1'b0, c, 1'($urandom_range(0, 1)));
        end
        11: begin
          if ($urandom_range(0, 1)) put_u(high_unit());
          put_byte(1'b0, jsu_pkg::CH_BACKSLASH, 1'b0);
          put_byte(1'b0, jsu_pkg::CH_U, 1'b0);
          for (int i = $urandom_range(0, 3); i > 0; i--) put_byte(1'b0, hex_char(4'($urandom())), 1'b0);
          do c = 8'($urandom());
          while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
          put_byte(1'b0, c, 1'b0);
        end
        12: put_u(16'h0000);
        13: put_u(16'(16'hdc00 + $urandom_range(0, 16'h3ff)));
        14: begin
          put_u(high_unit());
          case ($urandom_range(0, 2))
            0: begin
              do c = 8'($urandom()); while (c == jsu_pkg::CH_BACKSLASH);
              put_byte(1'b0, c, 1'b0);
            end
            1: begin
              put_byte(1'b0, jsu_pkg::CH_BACKSLASH, 1'b0);
              do c = 8'($urandom()); while (c == jsu_pkg::CH_U);
              put_byte(1'b0, c, 1'b0);
            end
            default: begin
              case ($urandom_range(0, 2))
                0: put_u(bmp_unit());
                1: put_u(high_unit());
                default: put_u(16'h0000);
              endcase
            end
          endcase
        end
        15: text_bytes[text_bytes.size() - 1].fin = 1'b1;
        16: ;  // left open, next start marker abandons it
        default: put_byte(1'b0, jsu_pkg::CH_QUOTE, 1'($urandom_range(0, 9) == 0));
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      for (int i = $urandom_range(1, 2); i > 0; i--)
        put_byte(1'b0, 8'($urandom()), 1'($urandom_range(0, 1)));
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        unescape_byte(start_of_string, data_byte, last_available);
        void'(text_bytes.pop_front());
        idle_left = (text_bytes.size() > 0) ? text_bytes[0].gap : 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (text_bytes.size() > 0 &&
                     !(text_bytes[0].drain && utf8_expected.size() > 0)) begin
          in_valid        <= 1'b1;
          start_of_string <= text_bytes[0].sos;
          data_byte       <= text_bytes[0].ch;
          last_available  <= text_bytes[0].fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (utf8_expected.size() == 0) begin
          $error("unexpected result: out_byte %02h result_kind %0d error_code %0d",
                 out_byte, result_kind, error_code);
          fail_count++;
        end else begin
          want = utf8_expected.pop_front();
          if (out_byte !== want.ob) begin
            $error("out_byte: expected %02h, got %02h", want.ob, out_byte);
            fail_count++;
          end
          if (result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
            fail_count++;
          end
          if (error_code !== want.code) begin
            $error("error_code: expected %0d, got %0d", want.code, error_code);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      end
      if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = calm ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("json_string_unescape_utf8_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    put_byte(1'b1, "A", 1'b0);                   // start byte not a quote
    put_byte(1'b0, 8'h00, 1'b0);                 // idle, no start marker
    put_byte(1'b1, jsu_pkg::CH_QUOTE, 1'b0);
    put_byte(1'b0, 8'hff, 1'b0);
    put_u(16'hdbff);                             // highest supplementary code point
    put_u(16'hdfff);
    put_byte(1'b0, jsu_pkg::CH_QUOTE, 1'b1);     // close with last flag set
    put_byte(1'b1, jsu_pkg::CH_QUOTE, 1'b0);
    put_byte(1'b0, 8'h1f, 1'b0);                 // control byte
    put_byte(1'b1, jsu_pkg::CH_QUOTE, 1'b0);
    put_byte(1'b0, jsu_pkg::CH_BACKSLASH, 1'b0);
    put_byte(1'b0, "x", 1'b1);                   // unknown escape on last byte
    put_byte(1'b1, jsu_pkg::CH_QUOTE, 1'b0);
    put_byte(1'b0, "a", 1'b0);
    put_byte(1'b1, jsu_pkg::CH_QUOTE, 1'b0);     // restart mid-string
    put_byte(1'b0, jsu_pkg::CH_SPACE, 1'b1);     // input ends before close

    first_random = text_bytes.size();
    while (text_bytes.size() < first_random + RUN_ITEMS) put_string();
    text_bytes[first_random].drain = 1'b1;
    text_bytes[first_random + RUN_ITEMS / 2].drain = 1'b1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (text_bytes.size() > 0 || utf8_expected.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && utf8_expected.size() == 0) begin
      $display("json_string_unescape_utf8_core regression: pass");
    end else begin
      $display("json_string_unescape_utf8_core regression: fail");
    end
    $finish;
  end

endmodule
